/* design/wildcard_signature_scanner_assert.svh */
// Assertion macros shared by the scanner RTL.
`ifndef WILDCARD_SIGNATURE_SCANNER_ASSERT_SVH
`define WILDCARD_SIGNATURE_SCANNER_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every clock edge outside reset.
`define WSS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("wildcard_signature_scanner: property failed");

// Check that a condition never holds outside reset.
`define WSS_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("wildcard_signature_scanner: forbidden condition seen");

`else

`define WSS_ASSERT(lbl, clk, rst_n, prop)
`define WSS_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* design/wss_pkg.sv */
// Constants and types of the wildcard signature scanner.
package wss_pkg;

	// Defaults of the top-level parameters
	localparam int MAX_SIGNATURE_DEF = 16;
	localparam int POSITION_BITS_DEF = 20;

	// Fixed field and register widths
	localparam int OFFSET_BITS   = 20;
	localparam int SIG_LEN_BITS  = 5;
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_IDX_BITS  = 2;
	localparam int DATA_BYTES    = 8;
	localparam int SIG_BYTES     = 16;
	localparam int OUT_DATA_BITS = 24;

	// Signature byte that matches any stream byte
	localparam logic [7:0] WILDCARD_BYTE = 8'h2A;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SIG_LOW    = 2'd0,
		CFG_SIG_HIGH   = 2'd1,
		CFG_SIG_LEN    = 2'd2,
		CFG_REPORT_END = 2'd3
	} cfg_idx_t;

endpackage

/* design/wildcard_signature_scanner.sv */
// Wildcard signature scanner: accepts one stream byte per clock cycle while s_tready is high, and returns
// the result in the cycle after the byte that causes it. The byte is compared against all signature
// positions at once in combinational logic, so the scan rate is fixed by that comparison and
// not by the length of the signature. A search yields at most one result: the offset of the first
// match (start or end), or found=0 at the end-of-stream byte when there was no match. Other bytes
// only update the window, fill count and position. s_tready drops only while a finished result
// sits in the output register and the sink does not take it. No clearing pass after reset.
`include "wildcard_signature_scanner_assert.svh"

module wildcard_signature_scanner #(
	parameter int MAX_SIGNATURE = wss_pkg::MAX_SIGNATURE_DEF,
	parameter int POSITION_BITS = wss_pkg::POSITION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [wss_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [wss_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	// byte stream in
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] data_byte
	input  logic                                s_tlast,   // end_of_stream
	// result out
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [wss_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // [19:0] match_offset, rest zero
	output logic                                m_tuser    // [0] found
);

	localparam int LEN_BITS = $clog2(MAX_SIGNATURE + 1);
	localparam int IDX_BITS = (MAX_SIGNATURE > 1) ? $clog2(MAX_SIGNATURE) : 1;
	localparam int WIDE_BITS = POSITION_BITS + wss_pkg::OFFSET_BITS;

	// Configuration registers
	logic [wss_pkg::DATA_BYTES*8-1:0]   sig_lo_q;
	logic [wss_pkg::DATA_BYTES*8-1:0]   sig_hi_q;
	logic [wss_pkg::SIG_LEN_BITS-1:0]   sig_len_q;
	logic                               rep_end_q;

	// Search state
	logic [MAX_SIGNATURE-1:0][7:0]      win_q;
	logic [LEN_BITS-1:0]                fill_q;
	logic [POSITION_BITS-1:0]           pos_q;
	logic                               matched_q;

	// Result register
	logic                               out_valid_q;
	logic                               found_q;
	logic [wss_pkg::OFFSET_BITS-1:0]    offset_q;

	logic                               accept;
	logic                               load_result;
	logic [wss_pkg::SIG_BYTES-1:0][7:0] sig_bytes;
	logic [LEN_BITS-1:0]                len_act;
	logic [MAX_SIGNATURE-1:0][7:0]      win_next;
	logic [LEN_BITS-1:0]                fill_next;
	logic [POSITION_BITS-1:0]           pos_next;
	logic [MAX_SIGNATURE-1:0]           byte_ok;
	logic                               hit;
	logic [POSITION_BITS-1:0]           off_pos;
	logic [WIDE_BITS-1:0]               off_wide;

	assign s_tready    = !out_valid_q || m_tready;
	assign accept      = s_tvalid && s_tready;
	assign sig_bytes   = {sig_hi_q, sig_lo_q};

	// Clamp the signature length to 1..MAX_SIGNATURE
	always_comb begin
		if (sig_len_q == '0) begin
			len_act = LEN_BITS'(1);
		end else if (sig_len_q > wss_pkg::SIG_LEN_BITS'(MAX_SIGNATURE)) begin
			len_act = LEN_BITS'(MAX_SIGNATURE);
		end else begin
			len_act = sig_len_q[LEN_BITS-1:0];
		end
	end

	// Shift the new byte into the window, newest at entry 0
	always_comb begin
		win_next[0] = s_tdata;
		for (int k = 1; k < MAX_SIGNATURE; k++) begin
			win_next[k] = win_q[k-1];
		end
	end

	// Compare every signature position against the shifted window in parallel
	always_comb begin
		logic [LEN_BITS-1:0] win_idx;
		logic [7:0]          sig;
		for (int i = 0; i < MAX_SIGNATURE; i++) begin
			win_idx = len_act - LEN_BITS'(1) - LEN_BITS'(i);
			sig  = sig_bytes[i];
			byte_ok[i] = (LEN_BITS'(i) >= len_act) || (sig == wss_pkg::WILDCARD_BYTE)
				|| (sig == win_next[win_idx[IDX_BITS-1:0]]);
		end
	end

	// Advance fill count and saturating position
	assign fill_next = (fill_q < LEN_BITS'(MAX_SIGNATURE)) ? fill_q + LEN_BITS'(1) : fill_q;
	assign pos_next  = (pos_q == '1) ? pos_q : pos_q + POSITION_BITS'(1);

	assign hit = !matched_q && (fill_next >= len_act) && (&byte_ok);

	// Offset of the match start or end, resized to the offset field
	assign off_pos  = rep_end_q ? pos_next : pos_next - POSITION_BITS'(len_act);
	assign off_wide = {{wss_pkg::OFFSET_BITS{1'b0}}, off_pos};

	assign load_result = accept && !matched_q && (hit || s_tlast);

	// Hold configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_lo_q  <= '0;
			sig_hi_q  <= '0;
			sig_len_q <= wss_pkg::SIG_LEN_BITS'(1);
			rep_end_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (wss_pkg::cfg_idx_t'(cfg_index))
				wss_pkg::CFG_SIG_LOW:    sig_lo_q  <= cfg_data;
				wss_pkg::CFG_SIG_HIGH:   sig_hi_q  <= cfg_data;
				wss_pkg::CFG_SIG_LEN:    sig_len_q <= cfg_data[wss_pkg::SIG_LEN_BITS-1:0];
				wss_pkg::CFG_REPORT_END: rep_end_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Update the search state on each accepted byte until a match; clear it at end of stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= '0;
			fill_q    <= '0;
			pos_q     <= '0;
			matched_q <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				win_q     <= '0;
				fill_q    <= '0;
				pos_q     <= '0;
				matched_q <= 1'b0;
			end else if (!matched_q) begin
				win_q     <= win_next;
				fill_q    <= fill_next;
				pos_q     <= pos_next;
				matched_q <= hit;
			end
		end
	end

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			found_q  <= hit;
			offset_q <= hit ? off_wide[wss_pkg::OFFSET_BITS-1:0] : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = {{(wss_pkg::OUT_DATA_BITS - wss_pkg::OFFSET_BITS){1'b0}}, offset_q};

	// A not-found result always carries offset zero
	`WSS_ASSERT(a_notfound_zero, clk, arst_n, (out_valid_q && !found_q) |-> (offset_q == '0))
	// An accepted end-of-stream byte leaves a cleared search behind
	`WSS_ASSERT(a_eos_clears, clk, arst_n,
		(accept && s_tlast) |=> (fill_q == '0 && pos_q == '0 && !matched_q))
	// The fill count never passes the window depth or the byte count
	`WSS_NEVER(a_fill_bound, clk, arst_n,
		(fill_q > LEN_BITS'(MAX_SIGNATURE)) || (POSITION_BITS'(fill_q) > pos_q))
	// No result while a match is already reported in this search
	`WSS_NEVER(a_no_second_result, clk, arst_n, load_result && matched_q)

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the wildcard signature scanner: directed and random byte streams.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES  = 200_000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_BYTES  = 1800;
	localparam int POS_BITS      = wss_pkg::POSITION_BITS_DEF;
	localparam int PAD_BITS      = wss_pkg::OUT_DATA_BITS - wss_pkg::OFFSET_BITS;

	typedef struct {
		logic                            found;
		logic [wss_pkg::OFFSET_BITS-1:0] match_offset;
	} scan_result_t;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [wss_pkg::CFG_IDX_BITS-1:0]  cfg_index;
	logic [wss_pkg::CFG_DATA_BITS-1:0] cfg_data;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [7:0]                        s_tdata;   // [7:0] data_byte
	logic                              s_tlast;   // end_of_stream
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [wss_pkg::OUT_DATA_BITS-1:0] m_tdata;   // [19:0] match_offset, [23:20] zero
	logic                              m_tuser;   // [0] found

	// register copies as the block should hold them
	logic [63:0]                      sig_low_reg;
	logic [63:0]                      sig_high_reg;
	logic [wss_pkg::SIG_LEN_BITS-1:0] sig_len_reg;
	logic                             report_end_reg;

	// search state of the scanner
	logic [7:0]          window [wss_pkg::SIG_BYTES];
	int                  fill;
	logic [POS_BITS-1:0] position;
	bit                  sig_matched;

	scan_result_t pending_results[$];
	int           bytes_scanned;
	int           mismatch_count = 0;
	int           cycle_count = 0;
	int           burst_left;
	bit           gaps_enabled;

	wildcard_signature_scanner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver backpressure: always ready, coin flip, or occasional stall bursts
	int ready_mode = 0;
	int ready_left = 0;
	int stall_left = 0;
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 2);
			ready_left = $urandom_range(20, 200);
		end
		ready_left--;
		case (ready_mode)
			0: begin
				m_tready <= 1'b1;
			end
			1: begin
				m_tready <= 1'($urandom_range(0, 1));
			end
			default: begin
				if (stall_left > 0) begin
					stall_left--;
					m_tready <= 1'b0;
				end else if ($urandom_range(0, 9) == 0) begin
					stall_left = $urandom_range(1, 8);
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		endcase
	end

	// Compare each delivered result with the oldest expected one
	always @(posedge clk) begin
		scan_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: found %0d match_offset %0d",
					m_tuser, m_tdata[wss_pkg::OFFSET_BITS-1:0]);
				mismatch_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (m_tuser !== exp_res.found) begin
					$error("found: expected %0d, got %0d", exp_res.found, m_tuser);
					mismatch_count++;
				end
				if (m_tdata[wss_pkg::OFFSET_BITS-1:0] !== exp_res.match_offset) begin
					$error("match_offset: expected %0d, got %0d",
						exp_res.match_offset, m_tdata[wss_pkg::OFFSET_BITS-1:0]);
					mismatch_count++;
				end
				if (m_tdata[wss_pkg::OUT_DATA_BITS-1:wss_pkg::OFFSET_BITS] !== '0) begin
					$error("padding: expected %0d, got %0d", PAD_BITS'(0),
						m_tdata[wss_pkg::OUT_DATA_BITS-1:wss_pkg::OFFSET_BITS]);
					mismatch_count++;
				end
			end
		end
	end

	// Advance the search by one byte and queue the result it causes
	function automatic void scan_byte(input logic [7:0] data_byte, input logic end_of_stream);
		int           n;
		int           k;
		bit           hit;
		logic [7:0]   sig;
		scan_result_t res;
		if (!sig_matched) begin
			bytes_scanned++;
			n = (sig_len_reg == 0) ? 1
				: ((sig_len_reg > wss_pkg::SIG_BYTES) ? wss_pkg::SIG_BYTES : sig_len_reg);
			for (k = wss_pkg::SIG_BYTES - 1; k > 0; k--)
				window[k] = window[k - 1];
			window[0] = data_byte;
			if (fill < wss_pkg::SIG_BYTES)
				fill++;
			if (position != '1)
				position++;
			// oldest window byte lines up with signature byte 0
			hit = (fill >= n);
			for (k = 0; k < n; k++) begin
				sig = (k < 8) ? sig_low_reg[k*8 +: 8] : sig_high_reg[(k-8)*8 +: 8];
				if (sig != wss_pkg::WILDCARD_BYTE && sig != window[n - 1 - k])
					hit = 0;
			end
			if (hit) begin
				sig_matched = 1;
				res.found = 1'b1;
				res.match_offset = report_end_reg ? wss_pkg::OFFSET_BITS'(position)
					: wss_pkg::OFFSET_BITS'(position - POS_BITS'(n));
				pending_results.push_back(res);
			end else if (end_of_stream) begin
				res.found = 1'b0;
				res.match_offset = '0;
				pending_results.push_back(res);
			end
		end
		// end of search: start the next one from scratch
		if (end_of_stream) begin
			for (k = 0; k < wss_pkg::SIG_BYTES; k++)
				window[k] = 8'h00;
			fill = 0;
			position = '0;
			sig_matched = 0;
		end
	endfunction

	// Send one byte request, with random bursts and gaps on the input side
	task automatic send_byte(input logic [7:0] data_byte, input logic end_of_stream);
		int gap;
		if (gaps_enabled && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= data_byte;
		s_tlast <= end_of_stream;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (burst_left > 0)
			burst_left--;
		scan_byte(data_byte, end_of_stream);
	endtask

	// Hold the input until every expected result is out and the block has settled
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input wss_pkg::cfg_idx_t idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			wss_pkg::CFG_SIG_LOW:  sig_low_reg = value;
			wss_pkg::CFG_SIG_HIGH: sig_high_reg = value;
			wss_pkg::CFG_SIG_LEN:  sig_len_reg = value[wss_pkg::SIG_LEN_BITS-1:0];
			default:               report_end_reg = value[0];
		endcase
		@(posedge clk);
	endtask

	// Mostly bytes that occur in signatures, else any byte
	function automatic logic [7:0] stream_noise();
		logic [7:0] pick [5] = '{8'h2A, 8'h41, 8'h42, 8'h00, 8'hFF};
		if ($urandom_range(0, 1) == 0)
			return pick[$urandom_range(0, 4)];
		return 8'($urandom);
	endfunction

	// Reset register values: one-byte signature 0x00, start offsets
	task automatic test_reset_values();
		send_byte(8'h37, 1'b0);
		send_byte(8'h00, 1'b0);
		// bytes after a match and the end after a match give nothing
		send_byte(8'h00, 1'b0);
		send_byte(8'h55, 1'b1);
		// match on the only byte, which is also the last
		send_byte(8'h00, 1'b1);
	endtask

	// Length zero, length too large, full-length signature, miss before fill
	task automatic test_lengths();
		drain_results();
		write_register(wss_pkg::CFG_REPORT_END, 64'h1);
		write_register(wss_pkg::CFG_SIG_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
		write_register(wss_pkg::CFG_SIG_HIGH, {8{wss_pkg::WILDCARD_BYTE}});
		write_register(wss_pkg::CFG_SIG_LEN, 64'd31);
		for (int i = 0; i < wss_pkg::SIG_BYTES; i++)
			send_byte((i < 8) ? 8'hFF : 8'($urandom), i == wss_pkg::SIG_BYTES - 1);
		drain_results();
		write_register(wss_pkg::CFG_SIG_LOW, 64'h0000_0000_0000_00AB);
		write_register(wss_pkg::CFG_SIG_LEN, 64'd0);
		send_byte(8'h12, 1'b0);
		send_byte(8'hAB, 1'b1);
		drain_results();
		// two-byte signature, stream ends before the window fills
		write_register(wss_pkg::CFG_REPORT_END, 64'h0);
		write_register(wss_pkg::CFG_SIG_LEN, 64'd2);
		send_byte(8'h00, 1'b1);
		send_byte(8'hAB, 1'b0);
		send_byte(8'h01, 1'b1);
	endtask

	// Random configurations with searches that mostly plant the signature
	task automatic test_random_searches();
		int          goal;
		int          n;
		int          pick;
		int          searches;
		int          prefix;
		int          suffix;
		logic [63:0] word [2];
		logic [7:0]  sig;
		logic [7:0]  data_q[$];
		goal = bytes_scanned + RANDOM_BYTES;
		while (bytes_scanned < goal) begin
			drain_results();
			// new signature, weighted toward short lengths
			for (int w = 0; w < 2; w++)
				for (int b = 0; b < 8; b++) begin
					pick = $urandom_range(0, 9);
					word[w][b*8 +: 8] = (pick < 3) ? wss_pkg::WILDCARD_BYTE
						: (pick < 9) ? stream_noise() : 8'($urandom);
				end
			if ($urandom_range(0, 3) != 0)
				write_register(wss_pkg::CFG_SIG_LOW, word[0]);
			if ($urandom_range(0, 3) != 0)
				write_register(wss_pkg::CFG_SIG_HIGH, word[1]);
			pick = $urandom_range(0, 19);
			n = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(17, 31)
				: (pick < 4) ? 16 : (pick < 10) ? $urandom_range(1, 3) : $urandom_range(1, 16);
			write_register(wss_pkg::CFG_SIG_LEN, {$urandom, 27'($urandom), 5'(n)});
			if ($urandom_range(0, 2) != 0)
				write_register(wss_pkg::CFG_REPORT_END,
					{$urandom, 31'($urandom), 1'($urandom)});
			n = (sig_len_reg == 0) ? 1
				: ((sig_len_reg > wss_pkg::SIG_BYTES) ? wss_pkg::SIG_BYTES : sig_len_reg);
			searches = $urandom_range(2, 8);
			repeat (searches) begin
				data_q.delete();
				prefix = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40)
					: $urandom_range(0, 10);
				repeat (prefix) data_q.push_back(stream_noise());
				if ($urandom_range(0, 9) < 7) begin
					for (int k = 0; k < n; k++) begin
						sig = (k < 8) ? sig_low_reg[k*8 +: 8] : sig_high_reg[(k-8)*8 +: 8];
						data_q.push_back((sig == wss_pkg::WILDCARD_BYTE) ? 8'($urandom) : sig);
					end
					suffix = $urandom_range(0, 5);
					repeat (suffix) data_q.push_back(stream_noise());
				end
				if (data_q.size() == 0)
					data_q.push_back(stream_noise());
				// now and then leave the search open across the next phase
				pick = $urandom_range(0, 9);
				for (int i = 0; i < data_q.size(); i++)
					send_byte(data_q[i], (i == data_q.size() - 1) && pick != 0);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= wss_pkg::CFG_SIG_LOW;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		sig_low_reg = '0;
		sig_high_reg = '0;
		sig_len_reg = wss_pkg::SIG_LEN_BITS'(1);
		report_end_reg = 1'b0;
		for (int k = 0; k < wss_pkg::SIG_BYTES; k++)
			window[k] = 8'h00;
		fill = 0;
		position = '0;
		sig_matched = 0;
		bytes_scanned = 0;
		burst_left = 0;
		gaps_enabled = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_lengths();
		test_random_searches();
		drain_results();

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/wss_pkg.sv
design/wildcard_signature_scanner.sv
tb/testbench.sv
